// ===== src/glwa_pkg.sv =====
// Shared types, constants and helpers of the greedy line wrap and align unit.
// No dependencies; glwa_place, glwa_emit and the top level import it.
package glwa_pkg;

  localparam int unsigned LINE_GLYPHS_DEF = 32;
  localparam int unsigned CFG_IDX_W       = 3;
  localparam int unsigned CFG_DATA_W      = 16;
  localparam int unsigned IN_TDATA_W      = 56;
  localparam int unsigned OUT_TDATA_W     = 120;

  localparam logic [CFG_IDX_W-1:0] REG_BOX_LEFT    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_TOP     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_LIMIT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FONT_SIZE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ALIGN_MODE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WRAP_ENABLE = 3'd5;

  localparam logic [15:0] BOX_LEFT_RST    = 16'd0;
  localparam logic [15:0] BOX_TOP_RST     = 16'd0;
  localparam logic [15:0] RIGHT_LIMIT_RST = 16'd640;
  localparam logic [7:0]  FONT_SIZE_RST   = 8'd12;
  localparam logic [1:0]  ALIGN_MODE_RST  = 2'd0;
  localparam logic        WRAP_ENABLE_RST = 1'b1;

  localparam logic [1:0] ALIGN_LEFT   = 2'd0;
  localparam logic [1:0] ALIGN_RIGHT  = 2'd1;
  localparam logic [1:0] ALIGN_CENTRE = 2'd2;

  localparam logic [1:0] CODE_ORDINARY = 2'd0;
  localparam logic [1:0] CODE_NEWLINE  = 2'd1;
  localparam logic [1:0] CODE_TAB      = 2'd2;

  localparam logic [7:0] CHAR_NEWLINE = 8'd10;
  localparam logic [7:0] CHAR_TAB     = 8'd9;

  localparam logic [8:0]  LINE_GAP   = 9'd4;
  localparam logic [15:0] BOUND_HIGH = 16'h7fff;

  localparam logic KIND_GLYPH  = 1'b0;
  localparam logic KIND_BOUNDS = 1'b1;

  typedef struct packed {
    logic [15:0] cx;
    logic [11:0] cw;
    logic [15:0] rx;
    logic [1:0]  code;
  } glyph_entry_t;

  localparam int unsigned ENTRY_W = $bits(glyph_entry_t);

  typedef struct packed {
    logic [15:0] pen_y;
    logic [7:0]  font_size;
    logic [15:0] line_count;
    logic [15:0] shift;
  } line_ctx_t;

  typedef struct packed {
    logic [15:0] min_left;
    logic [15:0] min_top;
    logic [17:0] max_right;
    logic [17:0] max_bottom;
  } bounds_t;

  typedef struct packed {
    logic        kind;
    logic [15:0] box_x;
    logic [15:0] box_y;
    logic [15:0] box_w;
    logic [15:0] box_h;
    logic [15:0] render_x;
    logic [15:0] render_y;
    logic [15:0] line_number;
    logic [1:0]  control_code;
  } out_word_t;

  // truncating halves, then right or centre shift of the line
  function automatic logic [15:0] align_shift(logic [1:0] mode, logic [15:0] pen,
                                              logic [15:0] left, logic [15:0] limit);
    logic signed [17:0] span;
    logic signed [17:0] lw;
    logic signed [17:0] span_h;
    logic signed [17:0] lw_h;
    logic signed [17:0] d;
    span   = $signed({{2{limit[15]}}, limit}) - $signed({{2{left[15]}}, left});
    lw     = $signed({{2{pen[15]}}, pen}) - $signed({{2{left[15]}}, left});
    span_h = (span + $signed({17'd0, span[17]})) >>> 1;
    lw_h   = (lw + $signed({17'd0, lw[17]})) >>> 1;
    case (mode)
      ALIGN_RIGHT:  d = span - lw;
      ALIGN_CENTRE: d = span_h - lw_h;
      default:      d = '0;
    endcase
    return d[15:0];
  endfunction

endpackage

// ===== src/glwa_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies; holds the glyphs of the open line.
module glwa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== src/glwa_place.sv =====
// Glyph placement datapath: overflow test, cell width, render x, control code.
// Depends on glwa_pkg.
module glwa_place import glwa_pkg::*; (
  input  logic [15:0]  pen_x_i,
  input  logic [15:0]  limit_i,
  input  logic [7:0]   first_byte_i,
  input  logic         single_byte_i,
  input  logic [15:0]  ink_width_i,
  input  logic [15:0]  advance_i,
  input  logic [15:0]  origin_x_i,
  output logic         overflow_o,
  output logic         newline_o,
  output logic [11:0]  adv_px_o,
  output glyph_entry_t entry_o
);

  logic signed [21:0] pen_ink;
  logic signed [21:0] limit16;
  logic signed [20:0] t;
  logic signed [20:0] t_rnd;
  logic [20:0]        rx_full;
  logic [15:0]        wide;

  assign pen_ink = $signed({{2{pen_x_i[15]}}, pen_x_i, 4'd0}) + $signed({6'd0, ink_width_i});
  assign limit16 = $signed({{2{limit_i[15]}}, limit_i, 4'd0});
  assign overflow_o = pen_ink > limit16;

  // truncate toward zero on the divide by 16
  assign t       = $signed({pen_x_i[15], pen_x_i, 4'd0}) - $signed({{5{origin_x_i[15]}}, origin_x_i});
  assign t_rnd   = t + $signed({17'd0, {4{t[20]}}});
  assign rx_full = 21'(t_rnd >>> 4);

  assign wide     = (ink_width_i > advance_i) ? ink_width_i : advance_i;
  assign adv_px_o = advance_i[15:4];

  always_comb begin
    entry_o.cx   = pen_x_i;
    entry_o.cw   = wide[15:4];
    entry_o.rx   = rx_full[15:0];
    entry_o.code = CODE_ORDINARY;
    newline_o    = 1'b0;
    if (single_byte_i) begin
      if (first_byte_i == CHAR_NEWLINE) begin
        entry_o.code = CODE_NEWLINE;
        newline_o    = 1'b1;
      end else if (first_byte_i == CHAR_TAB) begin
        entry_o.code = CODE_TAB;
      end
    end
  end

endmodule

// ===== src/glwa_emit.sv =====
// Result formatter: builds a positioned glyph word or the text bounds word.
// Depends on glwa_pkg.
module glwa_emit import glwa_pkg::*; (
  input  glyph_entry_t entry_i,
  input  line_ctx_t    ctx_i,
  input  bounds_t      bounds_i,
  input  logic         rec_i,
  output out_word_t    word_o
);

  logic [8:0] lh;

  assign lh = {1'b0, ctx_i.font_size} + LINE_GAP;

  always_comb begin
    if (rec_i) begin
      word_o.kind         = KIND_BOUNDS;
      word_o.box_x        = bounds_i.min_left;
      word_o.box_y        = bounds_i.min_top;
      word_o.box_w        = bounds_i.max_right[15:0];
      word_o.box_h        = bounds_i.max_bottom[15:0];
      word_o.render_x     = '0;
      word_o.render_y     = '0;
      word_o.line_number  = ctx_i.line_count;
      word_o.control_code = CODE_ORDINARY;
    end else begin
      word_o.kind         = KIND_GLYPH;
      word_o.box_x        = entry_i.cx;
      word_o.box_y        = ctx_i.pen_y;
      word_o.box_w        = {4'd0, entry_i.cw};
      word_o.box_h        = {7'd0, lh};
      word_o.render_x     = entry_i.rx + ctx_i.shift;
      word_o.render_y     = ctx_i.pen_y + {8'd0, ctx_i.font_size};
      word_o.line_number  = ctx_i.line_count;
      word_o.control_code = entry_i.code;
    end
  end

endmodule

// ===== src/greedy_line_wrap_align_unit.sv =====
// Greedy line wrap and align unit, top level: sequencer, line buffer RAM, registers.
// Depends on glwa_pkg, glwa_ram, glwa_place and glwa_emit.
//
// Usage: glyph clusters enter on s_axis, one word per cluster, tlast marking the
// final cluster of a text. Positioned glyphs and one bounds record per text leave
// on m_axis, tlast on the final word caused by an input cluster. Registers are
// written over the cfg channel (index 0..5), by the user only while the unit is idle;
// the unit itself does not enforce this. A cluster that closes no line passes accept
// (ST_IN), break test (ST_DECIDE) and buffer write (ST_PLACE). A line flush adds a
// setup step (ST_RD), then reads the held glyphs one at a time through the single
// read port of the line buffer RAM, one output word each (ST_OUT); the bounds
// record (ST_REC) follows at the end of a text.
// Results sit in one output register; a cluster may be accepted while it waits.
// When m_axis_tready is low the flush walk pauses and nothing is lost.
// Reset sets the registers to their defaults and leaves the unit idle; the
// first cluster of a text loads the pen from box_left and box_top.
module greedy_line_wrap_align_unit import glwa_pkg::*; #(
  parameter int unsigned LINE_GLYPHS = LINE_GLYPHS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // first_byte, ink_width, advance, origin_x
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // single_byte
  input  logic                   s_axis_tuser,
  input  logic                   s_axis_tlast,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // box_x, box_y, box_w, box_h, render_x, render_y, line_number, control_code
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // kind
  output logic                   m_axis_tuser,
  output logic                   m_axis_tlast
);

  localparam int unsigned AW = $clog2(LINE_GLYPHS);
  localparam int unsigned FW = $clog2(LINE_GLYPHS + 1);

  typedef enum logic [2:0] {
    ST_IN, ST_DECIDE, ST_PLACE, ST_RD, ST_OUT, ST_REC
  } state_e;

  typedef enum logic [1:0] {
    FL_BREAK, FL_EOT, FL_FULL
  } flush_e;

  logic [15:0] box_left_q, box_top_q, limit_q;
  logic [7:0]  font_size_q;
  logic [1:0]  align_mode_q;
  logic        wrap_q;

  state_e      state_q;
  flush_e      fl_kind_q;
  logic        idle_q;
  logic [15:0] pen_x_q, pen_y_q, line_count_q;
  logic        after_nl_q;
  logic [FW-1:0] fill_q;
  logic [AW-1:0] rd_idx_q;
  logic [15:0] shift_q;
  bounds_t     bounds_q;

  logic [7:0]  in_fb_q;
  logic        in_single_q, in_eot_q;
  logic [15:0] in_ink_q, in_adv_q, in_org_q;

  logic        out_valid_q, out_last_q;
  out_word_t   out_word_q;

  logic         ovf, nl;
  logic [11:0]  adv_px;
  glyph_entry_t place_entry, rd_entry;
  logic [ENTRY_W-1:0] rd_data;
  line_ctx_t    ctx;
  out_word_t    emit_word;
  logic         out_free, out_load, in_acc, brk, rd_last, ram_we, ram_re;
  logic [AW-1:0] ram_raddr;
  logic [8:0]   lh;
  logic signed [17:0] right, bottom;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_left_q   <= BOX_LEFT_RST;
      box_top_q    <= BOX_TOP_RST;
      limit_q      <= RIGHT_LIMIT_RST;
      font_size_q  <= FONT_SIZE_RST;
      align_mode_q <= ALIGN_MODE_RST;
      wrap_q       <= WRAP_ENABLE_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_BOX_LEFT:    box_left_q   <= cfg_data_i;
        REG_BOX_TOP:     box_top_q    <= cfg_data_i;
        REG_RIGHT_LIMIT: limit_q      <= cfg_data_i;
        REG_FONT_SIZE:   font_size_q  <= cfg_data_i[7:0];
        REG_ALIGN_MODE:  align_mode_q <= cfg_data_i[1:0];
        REG_WRAP_ENABLE: wrap_q       <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  glwa_place u_place (
    .pen_x_i      (pen_x_q),
    .limit_i      (limit_q),
    .first_byte_i (in_fb_q),
    .single_byte_i(in_single_q),
    .ink_width_i  (in_ink_q),
    .advance_i    (in_adv_q),
    .origin_x_i   (in_org_q),
    .overflow_o   (ovf),
    .newline_o    (nl),
    .adv_px_o     (adv_px),
    .entry_o      (place_entry)
  );

  assign s_axis_tready = (state_q == ST_IN);
  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;
  assign out_load = out_free && ((state_q == ST_OUT) || (state_q == ST_REC));
  assign brk      = after_nl_q || (wrap_q && ovf);
  assign rd_last  = (FW'(rd_idx_q) + FW'(1)) == fill_q;
  assign lh       = {1'b0, font_size_q} + LINE_GAP;
  assign right    = $signed({{2{pen_x_q[15]}}, pen_x_q}) + $signed({6'd0, place_entry.cw});
  assign bottom   = $signed({{2{pen_y_q[15]}}, pen_y_q}) + $signed({9'd0, lh});

  assign ram_we    = (state_q == ST_PLACE);
  assign ram_re    = (state_q == ST_RD) || ((state_q == ST_OUT) && out_free && !rd_last);
  assign ram_raddr = (state_q == ST_OUT) ? rd_idx_q + AW'(1) : rd_idx_q;

  glwa_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(LINE_GLYPHS)
  ) u_line_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(fill_q[AW-1:0]),
    .wdata_i(place_entry),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(rd_data)
  );

  assign rd_entry       = glyph_entry_t'(rd_data);
  assign ctx.pen_y      = pen_y_q;
  assign ctx.font_size  = font_size_q;
  assign ctx.line_count = line_count_q;
  assign ctx.shift      = shift_q;

  glwa_emit u_emit (
    .entry_i (rd_entry),
    .ctx_i   (ctx),
    .bounds_i(bounds_q),
    .rec_i   (state_q == ST_REC),
    .word_o  (emit_word)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IN;
      fl_kind_q    <= FL_BREAK;
      idle_q       <= 1'b1;
      pen_x_q      <= '0;
      pen_y_q      <= '0;
      line_count_q <= '0;
      after_nl_q   <= 1'b0;
      fill_q       <= '0;
      rd_idx_q     <= '0;
      shift_q      <= '0;
      bounds_q     <= '0;
      in_fb_q      <= '0;
      in_single_q  <= 1'b0;
      in_eot_q     <= 1'b0;
      in_ink_q     <= '0;
      in_adv_q     <= '0;
      in_org_q     <= '0;
      out_valid_q  <= 1'b0;
      out_last_q   <= 1'b0;
      out_word_q   <= '0;
    end else begin
      out_valid_q <= out_load || (out_valid_q && !m_axis_tready);
      case (state_q)
        ST_IN: begin
          if (in_acc) begin
            in_fb_q     <= s_axis_tdata[7:0];
            in_ink_q    <= s_axis_tdata[23:8];
            in_adv_q    <= s_axis_tdata[39:24];
            in_org_q    <= s_axis_tdata[55:40];
            in_single_q <= s_axis_tuser;
            in_eot_q    <= s_axis_tlast;
            if (idle_q) begin
              idle_q              <= 1'b0;
              pen_x_q             <= box_left_q;
              pen_y_q             <= box_top_q;
              line_count_q        <= '0;
              after_nl_q          <= 1'b0;
              fill_q              <= '0;
              bounds_q.min_left   <= BOUND_HIGH;
              bounds_q.min_top    <= BOUND_HIGH;
              bounds_q.max_right  <= '0;
              bounds_q.max_bottom <= '0;
            end
            state_q <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          if (brk && (fill_q != '0)) begin
            fl_kind_q <= FL_BREAK;
            rd_idx_q  <= '0;
            state_q   <= ST_RD;
          end else begin
            if (brk) begin
              line_count_q <= line_count_q + 16'd1;
              pen_x_q      <= box_left_q;
              pen_y_q      <= pen_y_q + {7'd0, lh};
            end
            state_q <= ST_PLACE;
          end
        end
        ST_PLACE: begin
          if ($signed(pen_x_q) < $signed(bounds_q.min_left)) begin
            bounds_q.min_left <= pen_x_q;
          end
          if ($signed(pen_y_q) < $signed(bounds_q.min_top)) begin
            bounds_q.min_top <= pen_y_q;
          end
          if (right > $signed(bounds_q.max_right)) begin
            bounds_q.max_right <= right;
          end
          if (bottom > $signed(bounds_q.max_bottom)) begin
            bounds_q.max_bottom <= bottom;
          end
          pen_x_q    <= pen_x_q + {4'd0, adv_px};
          after_nl_q <= nl;
          fill_q     <= fill_q + FW'(1);
          rd_idx_q   <= '0;
          if (in_eot_q) begin
            fl_kind_q <= FL_EOT;
            state_q   <= ST_RD;
          end else if ((fill_q + FW'(1)) == FW'(LINE_GLYPHS)) begin
            fl_kind_q <= FL_FULL;
            state_q   <= ST_RD;
          end else begin
            state_q <= ST_IN;
          end
        end
        ST_RD: begin
          shift_q <= align_shift(align_mode_q, pen_x_q, box_left_q, limit_q);
          state_q <= ST_OUT;
        end
        ST_OUT: begin
          if (out_free) begin
            out_word_q  <= emit_word;
            out_last_q  <= rd_last && ((fl_kind_q == FL_FULL) ||
                                       ((fl_kind_q == FL_BREAK) && !in_eot_q));
            if (rd_last) begin
              fill_q <= '0;
              case (fl_kind_q)
                FL_BREAK: begin
                  line_count_q <= line_count_q + 16'd1;
                  pen_x_q      <= box_left_q;
                  pen_y_q      <= pen_y_q + {7'd0, lh};
                  state_q      <= ST_PLACE;
                end
                FL_FULL: begin
                  line_count_q <= line_count_q + 16'd1;
                  pen_x_q      <= box_left_q;
                  pen_y_q      <= pen_y_q + {7'd0, lh};
                  after_nl_q   <= 1'b0;
                  state_q      <= ST_IN;
                end
                default: begin
                  state_q <= ST_REC;
                end
              endcase
            end else begin
              rd_idx_q <= rd_idx_q + AW'(1);
            end
          end
        end
        ST_REC: begin
          if (out_free) begin
            out_word_q  <= emit_word;
            out_last_q  <= 1'b1;
            idle_q      <= 1'b1;
            state_q     <= ST_IN;
          end
        end
        default: begin
          state_q <= ST_IN;
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_word_q.kind;
  assign m_axis_tdata  = {6'd0, out_word_q.control_code, out_word_q.line_number,
                          out_word_q.render_y, out_word_q.render_x, out_word_q.box_h,
                          out_word_q.box_w, out_word_q.box_y, out_word_q.box_x};

endmodule
